// ----- sv/ttup_pkg.sv -----
// shared types and constants of the text to unsigned parser
`timescale 1ns / 1ps

package ttup_pkg;

    // default widths of the result fields
    localparam int VALUE_BITS_DEF  = 32;
    localparam int OFFSET_BITS_DEF = 16;

    // fixed field widths
    localparam int CHAR_BITS  = 8;
    localparam int BASE_BITS  = 6;
    localparam int DIGIT_BITS = 6;

    // configuration port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic [APB_ADDR_BITS-1:0] REG_NUMBER_BASE = 3'd0;

    // entries of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // characters with a meaning of their own
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LO_Z  = 8'h7a;
    localparam logic [CHAR_BITS-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UP_Z  = 8'h5a;
    localparam logic [CHAR_BITS-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_UP_X  = 8'h58;

    // bases that the prefix logic picks
    localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;

    // one classified character on its way from front to back
    typedef struct packed {
        logic [DIGIT_BITS-1:0] digit;    // digit value when alnum
        logic                  alnum;
        logic                  space;    // space or tab
        logic                  zero;
        logic                  xchar;    // x or X
        logic                  begins;
        logic [BASE_BITS-1:0]  base;     // register value seen with the word
    } t_token;

endpackage

// ----- sv/ttup_if.sv -----
// handshake channels for characters and parse results
`timescale 1ns / 1ps

interface ttup_char_if import ttup_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] character;
    logic                 begins_text;

    modport source (output valid, character, begins_text, input ready);
    modport sink   (input valid, character, begins_text, output ready);
endinterface

interface ttup_result_if import ttup_pkg::*; #(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_BITS-1:0]  parsed_value;
    logic [OFFSET_BITS-1:0] stop_offset;

    modport source (output valid, parsed_value, stop_offset, input ready);
    modport sink   (input valid, parsed_value, stop_offset, output ready);
endinterface

// ----- sv/ttup_front.sv -----
// front end: accepts characters and classifies them into tokens
`timescale 1ns / 1ps

module ttup_front import ttup_pkg::*; (
    ttup_char_if.sink            i_in,
    input  logic [BASE_BITS-1:0] i_cfg_base,
    output logic                 o_push_valid,
    output t_token               o_push_token,
    input  logic                 i_push_ready
);

    logic [CHAR_BITS-1:0] w_c;
    logic [CHAR_BITS-1:0] w_off;
    logic                 w_alnum;

    assign w_c = i_in.character;

    // digit value of alphanumeric characters
    always_comb begin
        w_alnum = 1'b1;
        w_off   = '0;
        if (w_c >= CH_ZERO && w_c <= CH_NINE) begin
            w_off = w_c - CH_ZERO;
        end else if (w_c >= CH_LO_A && w_c <= CH_LO_Z) begin
            w_off = w_c - CH_LO_A + 8'd10;
        end else if (w_c >= CH_UP_A && w_c <= CH_UP_Z) begin
            w_off = w_c - CH_UP_A + 8'd10;
        end else begin
            w_alnum = 1'b0;
        end
    end

    // token fields: digit value, prefix and whitespace flags, start mark and base
    always_comb begin
        o_push_token.digit  = w_off[DIGIT_BITS-1:0];
        o_push_token.alnum  = w_alnum;
        o_push_token.space  = (w_c == CH_SPACE) || (w_c == CH_TAB);
        o_push_token.zero   = (w_c == CH_ZERO);
        o_push_token.xchar  = (w_c == CH_LO_X) || (w_c == CH_UP_X);
        o_push_token.begins = i_in.begins_text;
        o_push_token.base   = i_cfg_base;
    end

    // word goes straight into the queue
    assign o_push_valid = i_in.valid;
    assign i_in.ready   = i_push_ready;

endmodule

// ----- sv/ttup_queue.sv -----
// short token queue between front and back
`timescale 1ns / 1ps

module ttup_queue import ttup_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    input  t_token i_push_token,
    output logic   o_push_ready,
    output logic   o_pop_valid,
    output t_token o_pop_token,
    input  logic   i_pop_ready
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_token              r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr, n_wr;
    logic [PTR_BITS-1:0] r_rd, n_rd;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                w_push, w_pop;

    assign o_push_ready = (r_cnt != CNT_BITS'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_token  = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // token storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_token;
        end
    end

endmodule

// ----- sv/ttup_back.sv -----
// back end: parse sequencer, accumulator and result register
`timescale 1ns / 1ps

module ttup_back import ttup_pkg::*; #(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pop_valid,
    input  t_token        i_pop_token,
    output logic          o_pop_ready,
    ttup_result_if.source o_out
);

    localparam logic [1:0] PH_DONE   = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_ZERO   = 2'd2;
    localparam logic [1:0] PH_DIGITS = 2'd3;
    localparam int         PROD_BITS = VALUE_BITS + BASE_BITS;

    logic [1:0]             r_phase, n_phase;
    logic [BASE_BITS-1:0]   r_base, n_base;
    logic [VALUE_BITS-1:0]  r_acc, n_acc;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic                   r_out_valid;
    logic [VALUE_BITS-1:0]  r_out_value;
    logic [OFFSET_BITS-1:0] r_out_offset;

    logic [1:0]             w_phase;
    logic [BASE_BITS-1:0]   w_base;
    logic [BASE_BITS-1:0]   w_dbase;
    logic [VALUE_BITS-1:0]  w_acc;
    logic [OFFSET_BITS-1:0] w_pos;
    logic [OFFSET_BITS-1:0] w_pos_inc;
    logic [PROD_BITS-1:0]   w_prod;
    logic [BASE_BITS:0]     w_dval;
    logic                   w_take;
    logic                   w_use_digit;
    logic                   w_result;

    // a word moves on when the result register is free or being drained
    assign o_pop_ready = !r_out_valid || o_out.ready;
    assign w_take      = i_pop_valid && o_pop_ready;

    // state as seen after a start of text
    assign w_phase = i_pop_token.begins ? PH_SKIP : r_phase;
    assign w_base  = i_pop_token.begins ? i_pop_token.base : r_base;
    assign w_acc   = i_pop_token.begins ? '0 : r_acc;
    assign w_pos   = i_pop_token.begins ? '0 : r_pos;

    // saturating position step
    assign w_pos_inc = (&w_pos) ? w_pos : w_pos + 1'b1;

    // non-alphanumeric reads as a digit above every base
    assign w_dval = i_pop_token.alnum ? {1'b0, i_pop_token.digit}
                                      : {1'b1, {BASE_BITS{1'b0}}};

    // base in force for a digit, with auto mode resolved
    always_comb begin
        w_dbase = w_base;
        if (w_base == BASE_AUTO) begin
            w_dbase = (w_phase == PH_ZERO) ? BASE_OCT : BASE_DEC;
        end
    end

    // multiply-accumulate
    assign w_prod = {{BASE_BITS{1'b0}}, w_acc} * {{VALUE_BITS{1'b0}}, w_dbase};

    // parse sequencer
    always_comb begin
        n_phase     = r_phase;
        n_base      = r_base;
        n_acc       = r_acc;
        n_pos       = r_pos;
        w_use_digit = 1'b0;
        w_result    = 1'b0;
        if (w_take) begin
            n_phase = w_phase;
            n_base  = w_base;
            n_acc   = w_acc;
            n_pos   = w_pos;
            unique case (w_phase)
                PH_SKIP: begin
                    if (i_pop_token.space) begin
                        n_pos = w_pos_inc;
                    end else if (i_pop_token.zero &&
                                 (w_base == BASE_AUTO || w_base == BASE_HEX)) begin
                        n_pos   = w_pos_inc;
                        n_phase = PH_ZERO;
                    end else begin
                        n_base      = w_dbase;
                        w_use_digit = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if (i_pop_token.xchar) begin
                        n_base  = BASE_HEX;
                        n_pos   = w_pos_inc;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_base      = w_dbase;
                        w_use_digit = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    w_use_digit = 1'b1;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
            if (w_use_digit) begin
                if (w_dval >= {1'b0, w_dbase}) begin
                    w_result = 1'b1;
                    n_phase  = PH_DONE;
                end else begin
                    n_acc   = w_prod[VALUE_BITS-1:0]
                            + {{(VALUE_BITS-DIGIT_BITS){1'b0}}, i_pop_token.digit};
                    n_pos   = w_pos_inc;
                    n_phase = PH_DIGITS;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DONE;
            r_base  <= '0;
            r_acc   <= '0;
            r_pos   <= '0;
        end else begin
            r_phase <= n_phase;
            r_base  <= n_base;
            r_acc   <= n_acc;
            r_pos   <= n_pos;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result) begin
            r_out_value  <= w_acc;
            r_out_offset <= w_pos;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.parsed_value = r_out_value;
    assign o_out.stop_offset  = r_out_offset;

`ifndef ASSERT_OFF
    // a result always ends the parse
    a_result_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_result |=> (r_phase == PH_DONE))
        else $error("parse still running after a result");

    // a word while done and without start leaves the accumulator alone
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && r_phase == PH_DONE && !i_pop_token.begins)
        |=> ($stable(r_acc) && $stable(r_pos)))
        else $error("state changed after end of parse");

    // within a text the position never goes back
    a_pos_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !i_pop_token.begins) |=> (r_pos >= $past(r_pos)))
        else $error("position went backward");

    // no result is issued over a pending one that is not drained
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !w_result)
        else $error("pending result overwritten");
`endif

endmodule

// ----- sv/text_to_unsigned_parser_core.sv -----
// top level: configuration port, front end, token queue and back end
// a terminating character passes through the token queue, and the result valid is registered in the back end
// one character per cycle while neither side stalls, with a combinational multiply-accumulate
// the two-entry token queue and the result register let either side stall alone
// reset: synchronous, clears the parse state, queue, result valid and base register
// no clearing pass after reset; characters are accepted as soon as it is released
`timescale 1ns / 1ps

module text_to_unsigned_parser_core import ttup_pkg::*; #(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    ttup_char_if.sink                i_in,
    ttup_result_if.source            o_out,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    logic [BASE_BITS-1:0] r_number_base;
    logic                 w_push_valid, w_push_ready;
    t_token               w_push_token;
    logic                 w_pop_valid, w_pop_ready;
    t_token               w_pop_token;

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= '0;
        end else if (psel && penable && pwrite && pready && paddr == REG_NUMBER_BASE) begin
            r_number_base <= pwdata[BASE_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_NUMBER_BASE) begin
            prdata = {{(APB_DATA_BITS-BASE_BITS){1'b0}}, r_number_base};
        end
    end

    // classification
    ttup_front u_front (
        .i_in         (i_in),
        .i_cfg_base   (r_number_base),
        .o_push_valid (w_push_valid),
        .o_push_token (w_push_token),
        .i_push_ready (w_push_ready)
    );

    // decoupling queue
    ttup_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_token (w_push_token),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_token  (w_pop_token),
        .i_pop_ready  (w_pop_ready)
    );

    // parsing
    ttup_back #(
        .VALUE_BITS  (VALUE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .i_pop_token (w_pop_token),
        .o_pop_ready (w_pop_ready),
        .o_out       (o_out)
    );

endmodule

// ----- test/ttup_checker.sv -----
// checker for the text to unsigned parser: predicts each parse and compares the result words
`timescale 1ns / 1ps

module ttup_checker import ttup_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    ttup_char_if                     i_chars,
    ttup_result_if                   i_results,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    input  logic                     pready,
    output int                       o_fail_count,
    output int                       o_pending
);

    // scan state of the parse in progress
    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_LEAD,
        SCAN_ZERO,
        SCAN_DIGITS
    } t_scan;

    typedef struct {
        logic [VALUE_BITS_DEF-1:0]  value;
        logic [OFFSET_BITS_DEF-1:0] offset;
    } t_parse_result;

    // digit value of a byte that is not alphanumeric
    localparam logic [6:0] NOT_DIGIT = 7'd64;

    t_scan                      scan = SCAN_IDLE;
    logic [BASE_BITS-1:0]       base_reg = BASE_AUTO;
    logic [BASE_BITS-1:0]       radix = BASE_AUTO;
    logic [VALUE_BITS_DEF-1:0]  acc = '0;
    logic [OFFSET_BITS_DEF-1:0] offset = '0;
    t_parse_result              parses_q[$];
    int                         fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic logic [6:0] digit_value(input logic [CHAR_BITS-1:0] ch);
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            return 7'(ch - CH_ZERO);
        end
        if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
            return 7'(ch - CH_LO_A) + 7'd10;
        end
        if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
            return 7'(ch - CH_UP_A) + 7'd10;
        end
        return NOT_DIGIT;
    endfunction

    // offset saturates at all ones
    task automatic bump_offset();
        if (offset != '1) begin
            offset = offset + 1'b1;
        end
    endtask

    // a digit of the radix accumulates, anything else ends the parse
    task automatic take_digit(input logic [CHAR_BITS-1:0] ch);
        logic [6:0]                d;
        logic [VALUE_BITS_DEF-1:0] mult;
        logic [VALUE_BITS_DEF-1:0] addend;
        t_parse_result             done;
        d = digit_value(ch);
        if (d >= {1'b0, radix}) begin
            done.value  = acc;
            done.offset = offset;
            parses_q.push_back(done);
            scan = SCAN_IDLE;
        end else begin
            mult   = VALUE_BITS_DEF'(radix);
            addend = VALUE_BITS_DEF'(d);
            acc    = acc * mult + addend;
            bump_offset();
            scan = SCAN_DIGITS;
        end
    endtask

    task automatic parse_word(input logic [CHAR_BITS-1:0] ch, input logic first);
        // a start latches the base register and clears the parse
        if (first) begin
            scan   = SCAN_LEAD;
            radix  = base_reg;
            acc    = '0;
            offset = '0;
        end
        case (scan)
            SCAN_LEAD: begin
                if (ch == CH_SPACE || ch == CH_TAB) begin
                    bump_offset();
                end else if (ch == CH_ZERO && (radix == BASE_AUTO || radix == BASE_HEX)) begin
                    bump_offset();
                    scan = SCAN_ZERO;
                end else begin
                    if (radix == BASE_AUTO) begin
                        radix = BASE_DEC;
                    end
                    take_digit(ch);
                end
            end
            SCAN_ZERO: begin
                // x after the zero is the hex prefix, even with no hex digit behind it
                if (ch == CH_LO_X || ch == CH_UP_X) begin
                    radix = BASE_HEX;
                    bump_offset();
                    scan = SCAN_DIGITS;
                end else begin
                    if (radix == BASE_AUTO) begin
                        radix = BASE_OCT;
                    end
                    take_digit(ch);
                end
            end
            SCAN_DIGITS: begin
                take_digit(ch);
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin : check_and_predict
        t_parse_result want;
        if (!i_rst_n) begin
            scan     = SCAN_IDLE;
            base_reg = BASE_AUTO;
            radix    = BASE_AUTO;
            acc      = '0;
            offset   = '0;
            parses_q.delete();
        end else begin
            // register write on the access phase
            if (psel && penable && pwrite && pready && paddr == REG_NUMBER_BASE) begin
                base_reg = pwdata[BASE_BITS-1:0];
            end
            // result word against the oldest prediction
            if (i_results.valid && i_results.ready) begin
                if (parses_q.size() == 0) begin
                    $error("unexpected result: parsed_value %h stop_offset %0d",
                           i_results.parsed_value, i_results.stop_offset);
                    fail_count++;
                end else begin
                    want = parses_q.pop_front();
                    if (i_results.parsed_value !== want.value) begin
                        $error("parsed_value: expected %h, actual %h",
                               want.value, i_results.parsed_value);
                        fail_count++;
                    end
                    if (i_results.stop_offset !== want.offset) begin
                        $error("stop_offset: expected %0d, actual %0d",
                               want.offset, i_results.stop_offset);
                        fail_count++;
                    end
                end
            end
            // character word into the predictor
            if (i_chars.valid && i_chars.ready) begin
                parse_word(i_chars.character, i_chars.begins_text);
            end
        end
        o_pending <= parses_q.size();
    end

endmodule

// ----- test/tb_top.sv -----
// testbench top for the text to unsigned parser: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top import ttup_pkg::*;;

    localparam int     CLK_HALF_NS  = 4;
    localparam int     RESET_CYCLES = 5;
    localparam int     ITEM_TARGET  = 950;
    localparam int     PHASE_ITEMS  = 80;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     DRAIN_CYCLES = 8;
    localparam int     SETTLE_LIMIT = 4000;
    localparam longint LIMIT_NS     = 5_000_000;

    localparam logic [BASE_BITS-1:0] BASE_UNARY = 6'd1;
    localparam logic [BASE_BITS-1:0] BASE_MAX   = 6'd63;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    int fail_count;
    int pending;

    // pacing controls of the send side and the result side
    logic tx_calm;
    logic rx_calm;
    logic hold_req;
    int   gap_odds;

    int                   words_sent;
    int                   useful_len;
    logic [CHAR_BITS-1:0] text_q[$];

    ttup_char_if   char_if ();
    ttup_result_if res_if ();

    text_to_unsigned_parser_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ttup_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_chars      (char_if),
        .i_results    (res_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #LIMIT_NS;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin : result_side
        int   left;
        logic stall;
        logic held;
        left  = 0;
        stall = 1'b0;
        held  = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held         = 1'b1;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                left = 0;
            end else begin
                if (left == 0) begin
                    stall = !rx_calm && ($urandom_range(0, 2) == 0);
                    left  = stall ? $urandom_range(1, 14) : $urandom_range(1, 24);
                end
                res_if.ready <= !stall;
                left--;
            end
        end
    end

    function automatic logic [CHAR_BITS-1:0] digit_char(input int v);
        if (v < 10) begin
            return CH_ZERO + CHAR_BITS'(v);
        end
        if ($urandom_range(0, 1)) begin
            return CH_LO_A + CHAR_BITS'(v - 10);
        end
        return CH_UP_A + CHAR_BITS'(v - 10);
    endfunction

    function automatic logic is_alnum(input logic [CHAR_BITS-1:0] ch);
        return (ch >= CH_ZERO && ch <= CH_NINE) || (ch >= CH_LO_A && ch <= CH_LO_Z) ||
               (ch >= CH_UP_A && ch <= CH_UP_Z);
    endfunction

    function automatic logic [BASE_BITS-1:0] base_for_phase(input int p);
        case (p)
            0:       return BASE_AUTO;
            1:       return BASE_HEX;
            2:       return BASE_DEC;
            3:       return BASE_OCT;
            4:       return BASE_UNARY;
            5:       return 6'd2;
            6:       return 6'd36;
            7:       return BASE_MAX;
            8:       return 6'd37;
            9:       return BASE_AUTO;
            default: return BASE_BITS'($urandom_range(0, 63));
        endcase
    endfunction

    // one character word, with an optional gap before it
    task automatic send_word(input logic [CHAR_BITS-1:0] ch, input logic first);
        if (!tx_calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            char_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        char_if.valid       <= 1'b1;
        char_if.character   <= ch;
        char_if.begins_text <= first;
        @(posedge i_clk);
        while (!char_if.ready) @(posedge i_clk);
    endtask

    // send the text buffer; restart_odds adds stray starts inside it
    task automatic send_text(input int restart_odds);
        logic first;
        for (int i = 0; i < text_q.size(); i++) begin
            first = (i == 0) || (restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
            send_word(text_q[i], first);
        end
        text_q.delete();
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
    endtask

    // stop sending, wait for every result, then let the pipe drain
    task automatic settle();
        int waited;
        char_if.valid <= 1'b0;
        @(posedge i_clk);
        waited = 0;
        while (pending != 0 && waited < SETTLE_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [BASE_BITS-1:0] b);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_NUMBER_BASE;
        pwdata  <= APB_DATA_BITS'(b);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // well-formed number: blanks, prefix, digits of the base, then a stop byte unless left open
    task automatic make_number(input logic [BASE_BITS-1:0] base);
        int                   radix;
        int                   top_digit;
        logic [CHAR_BITS-1:0] stop;
        text_q.delete();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) text_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        end
        radix = int'(base);
        if (base == BASE_AUTO) begin
            case ($urandom_range(0, 2))
                0: begin
                    text_q.push_back(CH_ZERO);
                    text_q.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
                    radix = BASE_HEX;
                end
                1: begin
                    text_q.push_back(CH_ZERO);
                    radix = BASE_OCT;
                end
                default: begin
                    text_q.push_back(digit_char($urandom_range(1, 9)));
                    radix = BASE_DEC;
                end
            endcase
        end else if (base == BASE_HEX && $urandom_range(0, 1)) begin
            text_q.push_back(CH_ZERO);
            text_q.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
        end
        top_digit = (radix >= 36) ? 35 : radix - 1;
        repeat ($urandom_range(0, 12)) text_q.push_back(digit_char($urandom_range(0, top_digit)));
        // now and then left open, so the next start cuts it off
        if ($urandom_range(0, 19) == 0) begin
            useful_len = text_q.size();
            return;
        end
        if (radix < 36 && $urandom_range(0, 1)) begin
            stop = digit_char($urandom_range(radix, 35));
        end else begin
            stop = CHAR_BITS'($urandom_range(0, 255));
            while (is_alnum(stop)) stop = CHAR_BITS'($urandom_range(0, 255));
        end
        text_q.push_back(stop);
        useful_len = text_q.size();
        // bytes after the stop are ignored
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 3)) text_q.push_back(CHAR_BITS'($urandom_range(0, 255)));
        end
    endtask

    // random bytes leaning toward the ones that matter to the parser
    task automatic make_noise();
        text_q.delete();
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 3))
                0:       text_q.push_back(CHAR_BITS'($urandom_range(0, 255)));
                1:       text_q.push_back(digit_char($urandom_range(0, 35)));
                2:       text_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_ZERO);
                default: text_q.push_back($urandom_range(0, 1) ? CH_UP_X : CH_TAB);
            endcase
        end
    endtask

    initial begin : stimulus
        logic [BASE_BITS-1:0] base;
        int                   phase_no;
        int                   phase_start;
        char_if.valid       <= 1'b0;
        char_if.character   <= '0;
        char_if.begins_text <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        hold_req            <= 1'b0;
        rx_calm             <= 1'b0;
        tx_calm    = 1'b0;
        gap_odds   = 3;
        words_sent = 0;
        useful_len = 0;
        i_rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // auto base from reset: hex prefix after blanks, then a byte while done
        put_str(" \t0x1F!z");
        send_text(0);
        // hex prefix with no hex digit behind it
        put_str("0xg");
        send_text(0);
        // leading zero selects octal, so 8 stops it
        put_str("0178");
        send_text(0);

        // value wraps past 32 bits
        settle();
        write_base(BASE_HEX);
        put_str("fffffffff.");
        send_text(0);

        // base one: only zero is a digit, stopped by a null byte
        settle();
        write_base(BASE_UNARY);
        put_str("00");
        text_q.push_back(8'h00);
        send_text(0);

        // base above 36 takes every letter, stopped by 0xff
        settle();
        write_base(BASE_MAX);
        put_str("zZ");
        text_q.push_back(8'hff);
        send_text(0);

        // result side holds off while short numbers keep coming
        settle();
        write_base(BASE_DEC);
        tx_calm = 1'b1;
        hold_req <= 1'b1;
        repeat (25) begin
            repeat ($urandom_range(1, 3)) text_q.push_back(digit_char($urandom_range(0, 9)));
            text_q.push_back(",");
            words_sent += text_q.size();
            send_text(0);
        end
        tx_calm = 1'b0;
        settle();

        // random phases, each with its own base and pacing
        phase_no = 0;
        while (words_sent < ITEM_TARGET) begin
            base = base_for_phase(phase_no);
            settle();
            write_base(base);
            case ($urandom_range(0, 2))
                0:       gap_odds = 0;
                1:       gap_odds = 8;
                default: gap_odds = 3;
            endcase
            if (words_sent >= ITEM_TARGET - 2 * PHASE_ITEMS) begin
                tx_calm = 1'b1;
                rx_calm <= 1'b1;
            end
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) == 0) begin
                    make_noise();
                    words_sent += text_q.size();
                    send_text(4);
                end else begin
                    make_number(base);
                    words_sent += useful_len;
                    send_text(0);
                end
            end
            phase_no++;
        end
        settle();

        // verdict
        if (pending != 0) begin
            $error("results still missing at end: %0d", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
